FILE: hdl/assert_macros.svh
// assertion macros shared by the route table modules
// no dependencies; take in with an include of the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

FILE: hdl/rtwa_pkg.sv
// types and constants of the route table with aging
// no dependencies; used by the controller, the datapath and the top level
package rtwa_pkg;

   // operation codes
   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_ERROR  = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_LOOKUP = 2'd3;

   // result kinds
   localparam logic KIND_LOOKUP  = 1'b0;
   localparam logic KIND_EXPIRED = 1'b1;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_MY_ADDRESS    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUTE_TIMEOUT = 1'b1;

   localparam logic [3:0] MY_ADDRESS_RESET    = 4'd0;
   localparam logic [7:0] ROUTE_TIMEOUT_RESET = 8'd30;

   typedef struct packed {
      logic [1:0]  operation;
      logic [3:0]  msg_source;
      logic [3:0]  msg_originator;
      logic        carries_sequence;
      logic [7:0]  msg_hops;
      logic [31:0] msg_orig_sequence;
      logic [3:0]  lost_node;
      logic [31:0] lost_sequence;
      logic [3:0]  query_node;
   } req_type;

   typedef struct packed {
      logic        result_kind;
      logic [3:0]  entry_node;
      logic        route_ok;
      logic [3:0]  next_node;
      logic [7:0]  route_hops;
      logic [31:0] route_sequence;
      logic        last_result;
   } rsp_type;

   // one route entry as held in the table memory
   typedef struct packed {
      logic        seq_known;
      logic [31:0] seq_number;
      logic [7:0]  hops;
      logic [3:0]  next_hop;
      logic [7:0]  lifetime;
   } entry_word_type;

   // datapath step commanded by the controller
   typedef enum logic [3:0] {
      STEP_NONE,
      STEP_SRC_RD,
      STEP_SRC_WR,
      STEP_ORIG_RD,
      STEP_ORIG_WR,
      STEP_LOST_RD,
      STEP_LOST_WR,
      STEP_LOOK_RD,
      STEP_LOOK_OUT,
      STEP_SCAN,
      STEP_FLUSH
   } step_type;

   typedef struct packed {
      logic     load;
      step_type step;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } status_type;

endpackage

FILE: hdl/rtwa_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module rtwa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/rtwa_ctrl.sv
// controller state machine of the route table: sequences the datapath steps
// depends on rtwa_pkg and assert_macros.svh
`include "assert_macros.svh"
module rtwa_ctrl
   import rtwa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] operation,
   output logic       busy,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRC_RD,
      ST_SRC_WR,
      ST_ORIG_RD,
      ST_ORIG_WR,
      ST_LOST_RD,
      ST_LOST_WR,
      ST_LOOK_RD,
      ST_LOOK_OUT,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   state_type  state_ff, state_in;
   logic       busy_ff;
   logic [1:0] op_ff;
   logic       accept;
   step_type   step;

   assign accept = start && !busy_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (operation)
                  OP_UPDATE, OP_ERROR: state_in = ST_SRC_RD;
                  OP_TICK:             state_in = ST_SCAN;
                  default:             state_in = ST_LOOK_RD;
               endcase
            end
         end
         ST_SRC_RD:  state_in = ST_SRC_WR;
         ST_SRC_WR:  state_in = ST_ORIG_RD;
         ST_ORIG_RD: state_in = ST_ORIG_WR;
         ST_ORIG_WR: state_in = (op_ff == OP_ERROR) ? ST_LOST_RD : ST_IDLE;
         ST_LOST_RD: state_in = ST_LOST_WR;
         ST_LOST_WR: state_in = ST_IDLE;
         ST_LOOK_RD: state_in = ST_LOOK_OUT;
         ST_LOOK_OUT: state_in = ST_IDLE;
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH:   state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
         op_ff    <= OP_UPDATE;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
         if (accept) begin
            op_ff <= operation;
         end
      end
   end

   // datapath step for the current state
   always_comb begin
      case (state_ff)
         ST_SRC_RD:   step = STEP_SRC_RD;
         ST_SRC_WR:   step = STEP_SRC_WR;
         ST_ORIG_RD:  step = STEP_ORIG_RD;
         ST_ORIG_WR:  step = STEP_ORIG_WR;
         ST_LOST_RD:  step = STEP_LOST_RD;
         ST_LOST_WR:  step = STEP_LOST_WR;
         ST_LOOK_RD:  step = STEP_LOOK_RD;
         ST_LOOK_OUT: step = STEP_LOOK_OUT;
         ST_SCAN:     step = STEP_SCAN;
         ST_FLUSH:    step = STEP_FLUSH;
         default:     step = STEP_NONE;
      endcase
   end

   assign cmd.load = accept;
   assign cmd.step = step;
   assign busy     = busy_ff;

   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy_ff, busy_ff, "accepted transaction did not raise busy")
   `ASSERT_NEXT(a_flush_idle, clock, reset, state_ff == ST_FLUSH, !busy_ff, "busy held after tick flush")
   `ASSERT_NEXT(a_src_pair, clock, reset, state_ff == ST_SRC_RD, state_ff == ST_SRC_WR, "sender read not followed by write")

endmodule

FILE: hdl/rtwa_datapath.sv
// datapath of the route table: request and config registers, table memory,
// read-modify-write of entries, aging scan and result register
// depends on rtwa_pkg, rtwa_ram and assert_macros.svh
`include "assert_macros.svh"
module rtwa_datapath
   import rtwa_pkg::*;
#(
   parameter int NODES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  req_type                req_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  cmd_type                cmd,
   output status_type             status,
   output logic                   rsp_valid,
   output rsp_type                rsp_data
);

   localparam int IDX_W  = $clog2(NODES);
   localparam int CNT_W  = $clog2(NODES + 1);
   localparam int WORD_W = $bits(entry_word_type);

   logic [3:0]       my_address_ff;
   logic [7:0]       route_timeout_ff;
   req_type          req_ff;
   logic [IDX_W-1:0] rd_addr_ff;
   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic             proc_valid_ff, proc_valid_in;
   logic [NODES-1:0] valid_ff, valid_in;
   logic [NODES-1:0] written_ff, written_in;
   logic             pend_valid_ff, pend_valid_in;
   rsp_type          pend_ff, pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              wr_en;
   entry_word_type    word;
   entry_word_type    new_word;

   logic        src_ok, orig_ok, lost_ok, query_ok;
   logic [31:0] seq_diff;
   logic        take_route;

   rtwa_ram #(
      .WIDTH (WORD_W),
      .DEPTH (NODES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (rd_addr_ff),
      .wr_data (new_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // address checks: own address is never entered, addresses past the table are ignored
   assign src_ok   = (req_ff.msg_source != my_address_ff)
                     && (32'(req_ff.msg_source) < 32'(NODES));
   assign orig_ok  = (req_ff.msg_originator != my_address_ff)
                     && (32'(req_ff.msg_originator) < 32'(NODES));
   assign lost_ok  = (32'(req_ff.lost_node) < 32'(NODES));
   assign query_ok = (32'(req_ff.query_node) < 32'(NODES));

   // read address selection
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      case (cmd.step)
         STEP_SRC_RD: begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(req_ff.msg_source);
         end
         STEP_ORIG_RD: begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(req_ff.msg_originator);
         end
         STEP_LOST_RD: begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(req_ff.lost_node);
         end
         STEP_LOOK_RD: begin
            rd_en   = 1'b1;
            rd_addr = IDX_W'(req_ff.query_node);
         end
         STEP_SCAN: begin
            rd_en   = (ptr_ff < CNT_W'(NODES));
            rd_addr = ptr_ff[IDX_W-1:0];
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // entry as read; a never-written entry reads as cleared
   assign word = written_ff[rd_addr_ff] ? entry_word_type'(rd_data) : '0;

   // wrapping sequence compare for a route request or reply
   assign seq_diff   = req_ff.msg_orig_sequence - word.seq_number;
   assign take_route = (req_ff.operation == OP_UPDATE) && req_ff.carries_sequence
                       && (!word.seq_known || ((seq_diff != 32'd0) && !seq_diff[31]));

   // entry update, aging and result formation
   always_comb begin
      new_word      = word;
      wr_en         = 1'b0;
      valid_in      = valid_ff;
      written_in    = written_ff;
      ptr_in        = ptr_ff;
      proc_valid_in = 1'b0;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;

      case (cmd.step)
         STEP_SRC_WR: begin
            if (src_ok) begin
               wr_en                = 1'b1;
               new_word.hops        = 8'd1;
               new_word.next_hop    = req_ff.msg_source;
               new_word.lifetime    = route_timeout_ff;
               valid_in[rd_addr_ff] = 1'b1;
            end
         end
         STEP_ORIG_WR: begin
            if (orig_ok) begin
               wr_en                = 1'b1;
               valid_in[rd_addr_ff] = 1'b1;
               if (take_route) begin
                  new_word.hops       = (req_ff.msg_hops == 8'hFF) ? 8'hFF
                                        : req_ff.msg_hops + 8'd1;
                  new_word.seq_number = req_ff.msg_orig_sequence;
                  new_word.seq_known  = 1'b1;
                  new_word.next_hop   = req_ff.msg_source;
               end
               new_word.lifetime = route_timeout_ff;
            end
         end
         STEP_LOST_WR: begin
            if (lost_ok) begin
               wr_en                = 1'b1;
               new_word.seq_number  = req_ff.lost_sequence;
               valid_in[rd_addr_ff] = 1'b0;
            end
         end
         STEP_LOOK_OUT: begin
            rsp_valid_in          = 1'b1;
            rsp_in.result_kind    = KIND_LOOKUP;
            rsp_in.entry_node     = req_ff.query_node;
            rsp_in.route_ok       = query_ok && valid_ff[rd_addr_ff];
            rsp_in.next_node      = query_ok ? word.next_hop : 4'd0;
            rsp_in.route_hops     = query_ok ? word.hops : 8'd0;
            rsp_in.route_sequence = query_ok ? word.seq_number : 32'd0;
            rsp_in.last_result    = 1'b1;
         end
         STEP_SCAN: begin
            // issue the next read while the previous entry is aged
            proc_valid_in = rd_en;
            if (rd_en) begin
               ptr_in = ptr_ff + CNT_W'(1);
            end
            if (proc_valid_ff && valid_ff[rd_addr_ff]) begin
               wr_en = 1'b1;
               if (word.lifetime <= 8'd1) begin
                  new_word.lifetime    = 8'd0;
                  valid_in[rd_addr_ff] = 1'b0;
                  // hold the expiry back one find so the last one can be marked
                  if (pend_valid_ff) begin
                     rsp_valid_in       = 1'b1;
                     rsp_in             = pend_ff;
                     rsp_in.last_result = 1'b0;
                  end
                  pend_valid_in          = 1'b1;
                  pend_in.result_kind    = KIND_EXPIRED;
                  pend_in.entry_node     = 4'(rd_addr_ff);
                  pend_in.route_ok       = 1'b0;
                  pend_in.next_node      = word.next_hop;
                  pend_in.route_hops     = word.hops;
                  pend_in.route_sequence = word.seq_number;
                  pend_in.last_result    = 1'b0;
               end else begin
                  new_word.lifetime = word.lifetime - 8'd1;
               end
            end
         end
         STEP_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_in             = pend_ff;
               rsp_in.last_result = 1'b1;
            end
            pend_valid_in = 1'b0;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase

      if (wr_en) begin
         written_in[rd_addr_ff] = 1'b1;
      end

      // fresh transaction restarts the scan state
      if (cmd.load) begin
         ptr_in        = '0;
         proc_valid_in = 1'b0;
         pend_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         my_address_ff    <= MY_ADDRESS_RESET;
         route_timeout_ff <= ROUTE_TIMEOUT_RESET;
         ptr_ff           <= '0;
         proc_valid_ff    <= 1'b0;
         valid_ff         <= '0;
         written_ff       <= '0;
         pend_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en && (csr_index == CSR_MY_ADDRESS)) begin
            my_address_ff <= csr_wdata[3:0];
         end
         if (csr_wr_en && (csr_index == CSR_ROUTE_TIMEOUT)) begin
            route_timeout_ff <= csr_wdata;
         end
         ptr_ff        <= ptr_in;
         proc_valid_ff <= proc_valid_in;
         valid_ff      <= valid_in;
         written_ff    <= written_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (rd_en) begin
         rd_addr_ff <= rd_addr;
      end
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign status.scan_done = (ptr_ff == CNT_W'(NODES)) && !proc_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;

   `ASSERT_PROP(a_valid_written, clock, reset,
      $countones(valid_ff & ~written_ff) == 0, "valid route on never-written entry")
   `ASSERT_IMPLY(a_proc_after_read, clock, reset,
      proc_valid_ff, $past(rd_en), "scan entry aged without a read")
   `ASSERT_IMPLY(a_expired_invalid, clock, reset,
      rsp_valid_ff && (rsp_ff.result_kind == KIND_EXPIRED), !rsp_ff.route_ok,
      "expired route reported valid")

endmodule

FILE: hdl/route_table_with_aging.sv
// Route table with aging, top level. A transaction is taken when start is
// high and busy is low; busy stays high until the block can take the next.
// The busy time is set by the read-modify-write of each touched entry
// through the table memory with its registered read, and for a tick by the
// walk over all NODES entries, one per cycle. Results come as one-cycle
// strobes on rsp_valid and cannot be held off: a lookup answers after its
// read and output steps, as busy falls; a tick reports expired routes in
// ascending node order, each one as the next expiry is found, the last one
// marked by last_result from the flush step after the last entry is aged,
// as busy falls. The table is empty after reset with no clearing pass.
// Write configuration only while busy is low and no result is pending.
// depends on rtwa_pkg, rtwa_ctrl, rtwa_datapath and rtwa_ram
module route_table_with_aging
   import rtwa_pkg::*;
#(
   parameter int NODES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_type                req_data,
   output logic                   rsp_valid,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   rtwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_data.operation),
      .busy      (busy),
      .cmd       (cmd),
      .status    (status)
   );

   // table and result datapath
   rtwa_datapath #(
      .NODES (NODES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
